/* sv/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared codes and types for the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

   // opcodes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_STATUS = 2'd2;

   // sequencer phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_SLA   = 3'd2;
   localparam logic [2:0] PH_PTR   = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;

   // bus engine commands
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_SEND  = 3'd2;
   localparam logic [2:0] CMD_RXACK = 3'd3;
   localparam logic [2:0] CMD_RXNAK = 3'd4;
   localparam logic [2:0] CMD_STOP  = 3'd5;

   // masked TWI status codes
   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_REPSTART  = 8'h10;
   localparam logic [7:0] ST_MT_SLA_AK = 8'h18;
   localparam logic [7:0] ST_MT_SLA_NK = 8'h20;
   localparam logic [7:0] ST_MT_DAT_AK = 8'h28;
   localparam logic [7:0] ST_MT_DAT_NK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;
   localparam logic [7:0] ST_MR_SLA_AK = 8'h40;
   localparam logic [7:0] ST_MR_SLA_NK = 8'h48;
   localparam logic [7:0] ST_MR_DAT_AK = 8'h50;
   localparam logic [7:0] ST_MR_DAT_NK = 8'h58;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TRIES     = 1'd1;

   localparam logic [6:0] SLAVE_ADDRESS_RST = 7'd30;
   localparam logic [7:0] MAX_TRIES_RST     = 8'd200;

   typedef struct packed {
      logic [2:0] bus_command;
      logic [7:0] tx_byte;
      logic [7:0] rx_data;
      logic       rx_valid;
      logic       done_res;
      logic       failed;
      logic [7:0] byte_count;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/i2cms_req_if.sv */
// ----------------------------------------------------------------------------
// i2cms_req_if
// Request channel: transaction starts and bus status events.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] reg_addr;
   logic [7:0] length;
   logic [7:0] bus_status;
   logic [7:0] rx_byte;

   modport source (output valid, opcode, reg_addr, length, bus_status, rx_byte,
                   input ready);
   modport sink (input valid, opcode, reg_addr, length, bus_status, rx_byte,
                 output ready);
endinterface

`default_nettype wire

/* sv/i2cms_rsp_if.sv */
// ----------------------------------------------------------------------------
// i2cms_rsp_if
// Response channel: bus command and host-side status per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] bus_command;
   logic [7:0] tx_byte;
   logic [7:0] rx_data;
   logic       rx_valid;
   logic       done_res;
   logic       failed;
   logic [7:0] byte_count;

   modport source (output valid, bus_command, tx_byte, rx_data, rx_valid, done_res,
                   failed, byte_count, input ready);
   modport sink (input valid, bus_command, tx_byte, rx_data, rx_valid, done_res,
                 failed, byte_count, output ready);
endinterface

`default_nettype wire

/* sv/i2cms_csr_if.sv */
// ----------------------------------------------------------------------------
// i2cms_csr_if
// Configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_csr_if
   import i2cms_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/i2c_master_transaction_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_unit
// Steps an I2C master through pointer writes and reads over a byte engine.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  req_ch   | in  | opcode, reg_addr, length, bus_status, rx_byte
//  rsp_ch   | out | bus_command, tx_byte, rx_data, rx_valid, done_res,
//           |     | failed, byte_count
//  csr_ch   | in  | index, data (0 slave_address, 1 max_tries)
//
//  one transaction in per cycle while req_ch.ready is high; its response is
//  registered. a two-entry output buffer (output register plus skid
//  register) keeps req_ch.ready high while one response waits, so a stalled
//  rsp_ch blocks input only after two pending responses.
//  synchronous reset clears the sequencer state and loads register defaults.
//  csr writes are always taken; csr_ch.ready is tied high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transaction_sequencer_unit
   import i2cms_pkg::*;
(
   input  wire  clock,
   input  wire  reset,
   i2cms_req_if.sink   req_ch,
   i2cms_rsp_if.source rsp_ch,
   i2cms_csr_if.sink   csr_ch
);

   logic [6:0] slave_address_ff;
   logic [7:0] max_tries_ff;

   logic [2:0] phase_ff,        phase_in;
   logic       is_read_ff,      is_read_in;
   logic [7:0] tries_used_ff,   tries_used_in;
   logic [7:0] bytes_left_ff,   bytes_left_in;
   logic [7:0] bytes_done_ff,   bytes_done_in;
   logic [7:0] pointer_byte_ff, pointer_byte_in;

   rsp_type res;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;

   logic       accept;
   logic [7:0] st;
   logic [7:0] left_dec;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign st           = req_ch.bus_status;
   assign left_dec     = bytes_left_ff - {7'd0, (bytes_left_ff != 8'd0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_ADDRESS_RST;
         max_tries_ff     <= MAX_TRIES_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SLAVE_ADDRESS: slave_address_ff <= csr_ch.data[6:0];
            CSR_MAX_TRIES:     max_tries_ff     <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      is_read_in      = is_read_ff;
      tries_used_in   = tries_used_ff;
      bytes_left_in   = bytes_left_ff;
      bytes_done_in   = bytes_done_ff;
      pointer_byte_in = pointer_byte_ff;
      res             = '0;

      if ((req_ch.opcode == OP_WRITE || req_ch.opcode == OP_READ)
          && phase_ff == PH_IDLE) begin
         is_read_in      = (req_ch.opcode == OP_READ);
         pointer_byte_in = req_ch.reg_addr;
         bytes_left_in   = (req_ch.opcode == OP_READ) ? req_ch.length : 8'd0;
         bytes_done_in   = 8'd0;
         // first attempt: only a zero limit fails here
         if (max_tries_ff == 8'd0) begin
            phase_in      = PH_IDLE;
            tries_used_in = 8'd0;
            res.done_res  = 1'b1;
            res.failed    = 1'b1;
         end else begin
            phase_in        = PH_START;
            tries_used_in   = 8'd1;
            res.bus_command = CMD_START;
         end
      end else if (req_ch.opcode == OP_STATUS) begin
         case (phase_ff)
            PH_START: begin
               if (st == ST_START || st == ST_REPSTART) begin
                  phase_in        = PH_SLA;
                  res.bus_command = CMD_SEND;
                  res.tx_byte     = {slave_address_ff, is_read_ff};
               end else if (st == ST_ARB_LOST) begin
                  res.bus_command = CMD_START;
               end else begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  res.failed   = 1'b1;
               end
            end
            PH_SLA: begin
               if (st == ST_ARB_LOST) begin
                  phase_in        = PH_START;
                  res.bus_command = CMD_START;
               end else if (!is_read_ff && st == ST_MT_SLA_AK) begin
                  phase_in        = PH_PTR;
                  res.bus_command = CMD_SEND;
                  res.tx_byte     = pointer_byte_ff;
               end else if (is_read_ff && st == ST_MR_SLA_AK) begin
                  if (bytes_left_ff == 8'd0) begin
                     phase_in        = PH_IDLE;
                     res.bus_command = CMD_STOP;
                     res.done_res    = 1'b1;
                  end else begin
                     phase_in        = PH_DATA;
                     res.bus_command = (bytes_left_ff > 8'd1) ? CMD_RXACK : CMD_RXNAK;
                  end
               end else if ((!is_read_ff && st == ST_MT_SLA_NK)
                            || (is_read_ff && st == ST_MR_SLA_NK)) begin
                  // address nack: retry while tries remain
                  if (tries_used_ff >= max_tries_ff) begin
                     phase_in     = PH_IDLE;
                     res.done_res = 1'b1;
                     res.failed   = 1'b1;
                  end else begin
                     tries_used_in   = tries_used_ff + 8'd1;
                     phase_in        = PH_START;
                     res.bus_command = CMD_START;
                  end
               end else begin
                  phase_in        = PH_IDLE;
                  res.bus_command = CMD_STOP;
                  res.done_res    = 1'b1;
                  res.failed      = 1'b1;
               end
            end
            PH_PTR: begin
               if (st == ST_MT_DAT_AK || st == ST_MT_DAT_NK) begin
                  phase_in        = PH_IDLE;
                  res.bus_command = CMD_STOP;
                  res.done_res    = 1'b1;
               end else if (st == ST_ARB_LOST) begin
                  phase_in        = PH_START;
                  res.bus_command = CMD_START;
               end else begin
                  phase_in        = PH_IDLE;
                  res.bus_command = CMD_STOP;
                  res.done_res    = 1'b1;
                  res.failed      = 1'b1;
               end
            end
            PH_DATA: begin
               if (st == ST_MR_DAT_AK || st == ST_MR_DAT_NK) begin
                  res.rx_data   = req_ch.rx_byte;
                  res.rx_valid  = 1'b1;
                  bytes_done_in = bytes_done_ff + 8'd1;
                  bytes_left_in = left_dec;
                  if (st == ST_MR_DAT_NK || left_dec == 8'd0) begin
                     phase_in        = PH_IDLE;
                     res.bus_command = CMD_STOP;
                     res.done_res    = 1'b1;
                  end else begin
                     res.bus_command = (left_dec > 8'd1) ? CMD_RXACK : CMD_RXNAK;
                  end
               end else begin
                  phase_in        = PH_IDLE;
                  res.bus_command = CMD_STOP;
                  res.done_res    = 1'b1;
                  res.failed      = 1'b1;
               end
            end
            default: ;
         endcase
      end

      res.byte_count = bytes_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         is_read_ff      <= 1'b0;
         tries_used_ff   <= 8'd0;
         bytes_left_ff   <= 8'd0;
         bytes_done_ff   <= 8'd0;
         pointer_byte_ff <= 8'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         is_read_ff      <= is_read_in;
         tries_used_ff   <= tries_used_in;
         bytes_left_ff   <= bytes_left_in;
         bytes_done_ff   <= bytes_done_in;
         pointer_byte_ff <= pointer_byte_in;
      end
   end

   // output register with skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ch.ready) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_ff       <= res;
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_ff       <= res;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.bus_command = out_ff.bus_command;
   assign rsp_ch.tx_byte     = out_ff.tx_byte;
   assign rsp_ch.rx_data     = out_ff.rx_data;
   assign rsp_ch.rx_valid    = out_ff.rx_valid;
   assign rsp_ch.done_res    = out_ff.done_res;
   assign rsp_ch.failed      = out_ff.failed;
   assign rsp_ch.byte_count  = out_ff.byte_count;

endmodule

`default_nettype wire
